// ===== rtl/core/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and constants of the linear probing hash table
// Field widths, operation and status codes, and the layout of a table entry.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int unsigned KEY_W  = 31;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned SLOT_W = 5;
  localparam int unsigned STAT_W = 2;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

endpackage

// ===== rtl/core/lpht_mod.sv =====
// ----------------------------------------------------------------------------
// lpht_mod: key modulo table size by reciprocal multiplication
// The multiplier scales the key by a rounded-up reciprocal of the table size;
// the low bits of the quotient then give the remainder in a later registered step.
// ----------------------------------------------------------------------------
module lpht_mod #(
  parameter int unsigned TABLE_SIZE = 32,
  parameter int unsigned AW         = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [lpht_pkg::KEY_W-1:0] key_i,
  output logic                      done_o,
  output logic [AW-1:0]             rem_o
);

  localparam int unsigned KW = lpht_pkg::KEY_W;
  localparam int unsigned MW = KW + 1;
  localparam int unsigned PW = KW + MW;
  localparam int unsigned SH = KW + AW;
  // ceil(2^SH / TABLE_SIZE) gives the exact quotient for every key
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));
  localparam logic [AW-1:0] SIZE_LO = AW'(TABLE_SIZE);

  logic                             mul_q, mul_d;
  logic                             fold_q, fold_d;
  logic                             done_q, done_d;
  logic [KW-1:0]                    key_q, key_d;
  logic [PW-1:0]                    prod_q, prod_d;
  logic [AW-1:0]                    rem_q, rem_d;

  always_comb begin
    mul_d  = 1'b0;
    fold_d = 1'b0;
    done_d = done_q;
    key_d  = key_q;
    prod_d = prod_q;
    rem_d  = rem_q;
    if (start_i) begin
      mul_d  = 1'b1;
      done_d = 1'b0;
      key_d  = key_i;
    end else if (mul_q) begin
      prod_d = PW'(key_q) * PW'(RECIP);
      fold_d = 1'b1;
    end else if (fold_q) begin
      // the remainder is below 2^AW, so the low bits of key - q * size suffice
      rem_d  = key_q[AW-1:0] - prod_q[SH +: AW] * SIZE_LO;
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      fold_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      mul_q  <= mul_d;
      fold_q <= fold_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/core/lpht_mem.sv =====
// ----------------------------------------------------------------------------
// lpht_mem: table storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lpht_mem #(
  parameter int unsigned TABLE_SIZE = 32,
  parameter int unsigned AW         = 5
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  lpht_pkg::entry_t wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output lpht_pkg::entry_t rdata_o
);

  lpht_pkg::entry_t mem_q [TABLE_SIZE];
  lpht_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/linear_probe_hash_table_top.sv =====
// Flow: from accept to out_valid_o an item passes the modulo (multiply, then fold),
//   the home slot load, a read and a check per probe, the output register; 1 to 32 probes.
// Items: a new item is taken only in idle, once the previous probe walk through
//   the single read port of the table is done; a held result holds it back further.
// Reset: asynchronous, active low; afterwards a clearing pass over all TABLE_SIZE
//   slots marks every slot empty, and no item is taken until it ends.
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top: open addressing hash table, linear probing
// Insert takes the first empty slot from the home slot on; search stops at a
// matching key or an empty slot. Each walk is bounded to TABLE_SIZE probes.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top #(
  parameter int unsigned TABLE_SIZE = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         mode_i,
  input  logic [lpht_pkg::KEY_W-1:0]   key_i,
  input  logic [lpht_pkg::VAL_W-1:0]   value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [lpht_pkg::STAT_W-1:0]  status_o,
  output logic [lpht_pkg::VAL_W-1:0]   found_value_o,
  output logic [lpht_pkg::SLOT_W-1:0]  slot_o
);

  localparam int unsigned AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int unsigned CW = AW + 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]                   state_q, state_d;
  logic [AW-1:0]                s_q, s_d;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic                         mode_q, mode_d;
  logic [lpht_pkg::KEY_W-1:0]   key_q, key_d;
  logic [lpht_pkg::VAL_W-1:0]   value_q, value_d;
  logic [lpht_pkg::STAT_W-1:0]  res_status_q, res_status_d;
  logic [lpht_pkg::VAL_W-1:0]   res_value_q, res_value_d;
  logic [lpht_pkg::SLOT_W-1:0]  res_slot_q, res_slot_d;
  logic                         out_valid_q, out_valid_d;
  logic [lpht_pkg::STAT_W-1:0]  out_status_q, out_status_d;
  logic [lpht_pkg::VAL_W-1:0]   out_value_q, out_value_d;
  logic [lpht_pkg::SLOT_W-1:0]  out_slot_q, out_slot_d;

  logic                         in_accept;
  logic                         mod_done;
  logic [AW-1:0]                mod_rem;
  logic                         mem_we;
  lpht_pkg::entry_t             mem_wdata;
  logic                         mem_re;
  lpht_pkg::entry_t             mem_rdata;
  logic [AW-1:0]                s_next;
  logic                         walk_end;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  assign s_next   = (s_q == AW'(TABLE_SIZE - 1)) ? '0 : s_q + 1'b1;
  assign walk_end = (cnt_q == CW'(TABLE_SIZE - 1));

  lpht_mod #(
    .TABLE_SIZE (TABLE_SIZE),
    .AW         (AW)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_accept),
    .key_i   (key_i),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  lpht_mem #(
    .TABLE_SIZE (TABLE_SIZE),
    .AW         (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (s_q),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (s_q),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d      = state_q;
    s_d          = s_q;
    cnt_d        = cnt_q;
    mode_d       = mode_q;
    key_d        = key_q;
    value_d      = value_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    res_slot_d   = res_slot_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_slot_d   = out_slot_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_wdata    = '{valid: 1'b0, key: key_q, value: value_q};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (s_q == AW'(TABLE_SIZE - 1)) begin
          s_d     = '0;
          state_d = S_IDLE;
        end else begin
          s_d = s_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          mode_d  = mode_i;
          key_d   = key_i;
          value_d = value_i;
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (mod_done) begin
          s_d     = mod_rem;
          cnt_d   = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        mem_re  = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        res_value_d = '0;
        res_slot_d  = '0;
        state_d     = S_DONE;
        if (mode_q == lpht_pkg::MODE_INSERT) begin
          res_status_d = lpht_pkg::ST_FULL;
          if (!mem_rdata.valid) begin
            mem_we          = 1'b1;
            mem_wdata.valid = 1'b1;
            res_status_d    = lpht_pkg::ST_OK;
            res_slot_d      = lpht_pkg::SLOT_W'(s_q);
          end else if (!walk_end) begin
            state_d = S_READ;
          end
        end else begin
          res_status_d = lpht_pkg::ST_MISS;
          if (mem_rdata.valid) begin
            if (mem_rdata.key == key_q) begin
              res_status_d = lpht_pkg::ST_OK;
              res_value_d  = mem_rdata.value;
              res_slot_d   = lpht_pkg::SLOT_W'(s_q);
            end else if (!walk_end) begin
              state_d = S_READ;
            end
          end
        end
        // advance to the next slot, wrapping at the end of the table
        if (state_d == S_READ) begin
          s_d   = s_next;
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_value_d  = res_value_q;
          out_slot_d   = res_slot_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      s_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      s_q         <= s_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    key_q        <= key_d;
    value_q      <= value_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    res_slot_q   <= res_slot_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_slot_q   <= out_slot_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_value_o = out_value_q;
  assign slot_o        = out_slot_q;

endmodule

// ===== tb/linear_probe_hash_table_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top_test: self-checking bench for the hash table
// Feeds inserts and searches through the input handshake with random idling on
// both sides. A table model in the bench predicts status, handle and slot for
// every item taken, and each result is checked in order against it. A directed
// opening covers extreme keys and handles, wrap-around and duplicate keys. The
// random part fills the table with clustered keys, then keeps probing it full.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top_test;

  localparam int unsigned TABLE_SIZE  = 32;
  localparam int unsigned RAND_OPS    = 950;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYC   = 120;

  typedef struct packed {
    logic                       mode;
    logic [lpht_pkg::KEY_W-1:0] key;
    logic [lpht_pkg::VAL_W-1:0] value;
  } op_t;

  typedef struct packed {
    logic [lpht_pkg::STAT_W-1:0] status;
    logic [lpht_pkg::VAL_W-1:0]  found_value;
    logic [lpht_pkg::SLOT_W-1:0] slot;
  } lookup_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic                         mode_i = lpht_pkg::MODE_INSERT;
  logic [lpht_pkg::KEY_W-1:0]   key_i = '0;
  logic [lpht_pkg::VAL_W-1:0]   value_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [lpht_pkg::STAT_W-1:0]  status_o;
  logic [lpht_pkg::VAL_W-1:0]   found_value_o;
  logic [lpht_pkg::SLOT_W-1:0]  slot_o;

  // bench copy of the table
  bit                           tbl_valid [TABLE_SIZE];
  logic [lpht_pkg::KEY_W-1:0]   tbl_key   [TABLE_SIZE];
  logic [lpht_pkg::VAL_W-1:0]   tbl_value [TABLE_SIZE];

  op_t                          op_q[$];
  lookup_t                      lookup_exp_q[$];
  logic [lpht_pkg::KEY_W-1:0]   stored_keys[$];
  int unsigned                  gen_inserts = 0;

  bit                           in_taken = 1'b0;
  bit                           calm = 1'b0;
  int unsigned                  in_gap_left = 0;
  int unsigned                  out_stall_left = 0;
  int unsigned                  quiet_cycles = 0;
  int                           err_cnt = 0;

  linear_probe_hash_table_top #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .found_value_o(found_value_o),
    .slot_o       (slot_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Walk the table from the home slot; an insert takes the first empty slot,
  // a search stops at a matching key or an empty slot.
  task automatic probe_table(input logic mode, input logic [lpht_pkg::KEY_W-1:0] key,
                             input logic [lpht_pkg::VAL_W-1:0] value,
                             output lookup_t res);
    int unsigned s;
    int unsigned n;
    bit          done;
    s    = key % TABLE_SIZE;
    done = 1'b0;
    res.status      = (mode == lpht_pkg::MODE_INSERT) ? lpht_pkg::ST_FULL
                                                      : lpht_pkg::ST_MISS;
    res.found_value = '0;
    res.slot        = '0;
    for (n = 0; n < TABLE_SIZE && !done; n++) begin
      if (!tbl_valid[s]) begin
        if (mode == lpht_pkg::MODE_INSERT) begin
          tbl_valid[s] = 1'b1;
          tbl_key[s]   = key;
          tbl_value[s] = value;
          res.status   = lpht_pkg::ST_OK;
          res.slot     = s[lpht_pkg::SLOT_W-1:0];
        end
        done = 1'b1;
      end else if (mode == lpht_pkg::MODE_SEARCH && tbl_key[s] == key) begin
        res.status      = lpht_pkg::ST_OK;
        res.found_value = tbl_value[s];
        res.slot        = s[lpht_pkg::SLOT_W-1:0];
        done            = 1'b1;
      end
      if (!done) s = (s + 1) % TABLE_SIZE;
    end
  endtask

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [lpht_pkg::KEY_W-1:0] any_key();
    logic [lpht_pkg::KEY_W-1:0] k;
    k = lpht_pkg::KEY_W'($urandom);
    return k;
  endfunction

  // crowd keys onto four home slots (0, 8, 16, 24) to build long clusters
  function automatic logic [lpht_pkg::KEY_W-1:0] clustered_key();
    logic [lpht_pkg::KEY_W-1:0] k;
    k = lpht_pkg::KEY_W'($urandom);
    k[lpht_pkg::SLOT_W-1:0] = lpht_pkg::SLOT_W'($urandom_range(0, 3) * 8);
    return k;
  endfunction

  function automatic logic [lpht_pkg::KEY_W-1:0] stored_key();
    return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
  endfunction

  task automatic push_op(input logic mode, input logic [lpht_pkg::KEY_W-1:0] key,
                         input logic [lpht_pkg::VAL_W-1:0] value);
    op_q.push_back(op_t'{mode: mode, key: key, value: value});
    // every insert lands until the table is full
    if (mode == lpht_pkg::MODE_INSERT && gen_inserts < TABLE_SIZE) begin
      stored_keys.push_back(key);
      gen_inserts++;
    end
  endtask

  // input side: present the next item, hold it until taken, then idle
  always @(negedge clk_i) begin : drive_in
    op_t op;
    if (rst_ni) begin
      if (in_valid_i && !in_taken) begin
        // hold
      end else if (in_gap_left != 0) begin
        in_valid_i  <= 1'b0;
        in_gap_left <= in_gap_left - 1;
      end else if (op_q.size() != 0) begin
        op = op_q.pop_front();
        mode_i     <= op.mode;
        key_i      <= op.key;
        value_i    <= op.value;
        in_valid_i <= 1'b1;
        if ($urandom_range(0, 39) == 0) calm <= !calm;
        in_gap_left <= calm ? 0 : idle_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output side: random back-pressure, no new stall starts in calm stretches
  always @(negedge clk_i) begin : drive_out
    if (rst_ni) begin
      if (out_stall_left != 0) begin
        out_ready_i    <= 1'b0;
        out_stall_left <= out_stall_left - 1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready_i    <= 1'b0;
        out_stall_left <= idle_len();
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_out
    lookup_t want;
    lookup_t pred;
    if (rst_ni) begin
      in_taken <= in_valid_i && in_ready_o;
      // check before predicting so a stray result cannot claim a new item
      if (out_valid_o && out_ready_i) begin
        if (lookup_exp_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d value %h slot %0d",
                   $time, status_o, found_value_o, slot_o);
          err_cnt++;
        end else begin
          want = lookup_exp_q.pop_front();
          if (status_o !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, status_o);
            err_cnt++;
          end
          if (found_value_o !== want.found_value) begin
            $display("%0t: found_value mismatch, expected %h, actual %h",
                     $time, want.found_value, found_value_o);
            err_cnt++;
          end
          if (slot_o !== want.slot) begin
            $display("%0t: slot mismatch, expected %0d, actual %0d",
                     $time, want.slot, slot_o);
            err_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        probe_table(mode_i, key_i, value_i, pred);
        lookup_exp_q.push_back(pred);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("linear_probe_hash_table_top_test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int unsigned i;
    int unsigned r;
    // empty table, extreme keys and handles, wrap-around, duplicate keys
    push_op(lpht_pkg::MODE_SEARCH, '0, '1);
    push_op(lpht_pkg::MODE_INSERT, '0, '0);
    push_op(lpht_pkg::MODE_INSERT, '1, '1);
    push_op(lpht_pkg::MODE_INSERT, 31'd31, 32'hA5A5_A5A5);
    push_op(lpht_pkg::MODE_INSERT, '0, 32'h0000_1234);
    push_op(lpht_pkg::MODE_SEARCH, '0, 32'hFFFF_0000);
    push_op(lpht_pkg::MODE_SEARCH, '1, '1);
    push_op(lpht_pkg::MODE_SEARCH, 31'd31, '0);
    push_op(lpht_pkg::MODE_SEARCH, 31'd63, '0);
    push_op(lpht_pkg::MODE_INSERT, 31'd32, 32'h5A5A_5A5A);
    push_op(lpht_pkg::MODE_SEARCH, 31'd32, '0);
    push_op(lpht_pkg::MODE_SEARCH, 31'h4000_0000, '0);
    push_op(lpht_pkg::MODE_INSERT, 31'h7FFF_FFE0, 32'h8000_0000);
    push_op(lpht_pkg::MODE_SEARCH, 31'h7FFF_FFE0, '0);
    push_op(lpht_pkg::MODE_INSERT, 31'd16, 32'h7FFF_FFFF);
    push_op(lpht_pkg::MODE_SEARCH, 31'd16, '0);
    push_op(lpht_pkg::MODE_SEARCH, 31'd48, '0);

    // fill the table with clustered, duplicate and random keys, then keep probing it full
    for (i = 0; i < RAND_OPS; i++) begin
      r = $urandom_range(0, 99);
      if (gen_inserts < TABLE_SIZE) begin
        if (r < 25)      push_op(lpht_pkg::MODE_INSERT, clustered_key(), $urandom);
        else if (r < 35) push_op(lpht_pkg::MODE_INSERT, stored_key(), $urandom);
        else if (r < 50) push_op(lpht_pkg::MODE_INSERT, any_key(), $urandom);
        else if (r < 80) push_op(lpht_pkg::MODE_SEARCH, stored_key(), $urandom);
        else if (r < 90) push_op(lpht_pkg::MODE_SEARCH, clustered_key(), $urandom);
        else             push_op(lpht_pkg::MODE_SEARCH, any_key(), $urandom);
      end else begin
        if (r < 8)       push_op(lpht_pkg::MODE_INSERT, any_key(), $urandom);
        else if (r < 20) push_op(lpht_pkg::MODE_INSERT, stored_key(), $urandom);
        else if (r < 65) push_op(lpht_pkg::MODE_SEARCH, stored_key(), $urandom);
        else if (r < 80) push_op(lpht_pkg::MODE_SEARCH, clustered_key(), $urandom);
        else             push_op(lpht_pkg::MODE_SEARCH, any_key(), $urandom);
      end
    end

    while (op_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (lookup_exp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("linear_probe_hash_table_top_test passed");
    end else begin
      $display("linear_probe_hash_table_top_test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/lpht_pkg.sv
rtl/core/lpht_mod.sv
rtl/core/lpht_mem.sv
rtl/core/linear_probe_hash_table_top.sv
tb/linear_probe_hash_table_top_test.sv
